### rtl/mm4_pkg.sv
package mm4_pkg;

    localparam int DIM       = 4;
    localparam int IDX_W     = 2;
    localparam int CELLS     = DIM * DIM;
    localparam int CELL_W    = 2 * IDX_W;
    localparam int VAL_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int ACC_W     = PROD_W + $clog2(DIM);
    localparam int STEP_W    = $clog2(DIM + 2);

    localparam int S_TDATA_W = ((2 * IDX_W + 2 * VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * IDX_W + VAL_W + 7) / 8) * 8;

    typedef struct packed {
        logic acc_load;   // first product of an element: load accumulator
        logic acc_add;    // further products: add into accumulator
    } mac_ctrl_t;

endpackage

### rtl/mm4_mac.sv
module mm4_mac (
    input  logic                                aclk,
    input  mm4_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [mm4_pkg::VAL_W-1:0]    op_a,
    input  logic signed [mm4_pkg::VAL_W-1:0]    op_b,
    output logic        [mm4_pkg::VAL_W-1:0]    result,
    output logic                                sat
);

    logic signed [mm4_pkg::PROD_W-1:0] prod_reg;
    logic signed [mm4_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mm4_pkg::ACC_W-1:0]  acc_next;
    logic        [mm4_pkg::ACC_W-mm4_pkg::FRAC_BITS-mm4_pkg::VAL_W:0] top_bits;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.acc_load) begin
            acc_next = mm4_pkg::ACC_W'(prod_reg);
        end else if (ctrl.acc_add) begin
            acc_next = acc_reg + mm4_pkg::ACC_W'(prod_reg);
        end
    end

    // The shifted sum fits when every bit above its new sign bit repeats that sign.
    assign top_bits = acc_reg[mm4_pkg::ACC_W-1:mm4_pkg::FRAC_BITS+mm4_pkg::VAL_W-1];
    assign sat      = !((&top_bits) || (~|top_bits));

    always_comb begin
        if (!sat) begin
            result = acc_reg[mm4_pkg::FRAC_BITS+mm4_pkg::VAL_W-1:mm4_pkg::FRAC_BITS];
        end else if (acc_reg[mm4_pkg::ACC_W-1]) begin
            result = {1'b1, {(mm4_pkg::VAL_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(mm4_pkg::VAL_W-1){1'b1}}};
        end
    end

endmodule

### rtl/matrix_multiply_4x4_unit.sv
// Load request (no last mark): stored, and the input stays ready for another request.
// Last-marked request: the 16 elements are computed one at a time, each as 4
// multiplies through the one shared 32x32 multiplier into the product register
// and accumulator, then held in the output register until the sink takes it.
// Input is not ready while a product is being computed or sent.
// Synchronous active-low reset clears both stores to zero and idles the sequencer.
module matrix_multiply_4x4_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // row, column, left_value, right_value (from bit 0), zero padded
    input  logic [mm4_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_row, out_column, product_value (from bit 0), zero padded
    output logic [mm4_pkg::M_TDATA_W-1:0]   m_tdata,
    // saturated
    output logic                            m_tuser,
    output logic                            m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    localparam int IW = mm4_pkg::IDX_W;
    localparam int VW = mm4_pkg::VAL_W;
    localparam logic [mm4_pkg::STEP_W-1:0] STEP_LAST = mm4_pkg::STEP_W'(mm4_pkg::DIM + 1);
    localparam logic [mm4_pkg::STEP_W-1:0] STEP_ADD_END = mm4_pkg::STEP_W'(mm4_pkg::DIM);
    localparam logic [IW-1:0] IDX_MAX = IW'(mm4_pkg::DIM - 1);

    state_t                     state_reg, state_next;
    logic [mm4_pkg::STEP_W-1:0] step_reg, step_next;
    logic [IW-1:0]              row_reg, row_next;
    logic [IW-1:0]              col_reg, col_next;

    logic [VW-1:0] left_store_reg  [mm4_pkg::CELLS];
    logic [VW-1:0] right_store_reg [mm4_pkg::CELLS];

    logic                       m_valid_reg;
    logic [mm4_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                       m_sat_reg;
    logic                       m_last_reg;

    logic [IW-1:0]              in_row, in_col;
    logic [VW-1:0]              in_left, in_right;
    logic                       in_take;
    logic                       in_range;
    logic [IW-1:0]              k_idx;
    logic [mm4_pkg::CELL_W-1:0] left_addr, right_addr;
    logic [VW-1:0]              mac_result;
    logic                       mac_sat;
    logic                       elem_last;
    mm4_pkg::mac_ctrl_t         mac_ctrl;

    assign in_row   = s_tdata[IW-1:0];
    assign in_col   = s_tdata[2*IW-1:IW];
    assign in_left  = s_tdata[2*IW+VW-1:2*IW];
    assign in_right = s_tdata[2*IW+2*VW-1:2*IW+VW];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign in_range = ({1'b0, in_row} < (IW+1)'(mm4_pkg::DIM))
                   && ({1'b0, in_col} < (IW+1)'(mm4_pkg::DIM));

    // Operand k follows the step count while multiplies are issued.
    assign k_idx      = step_reg[IW-1:0];
    assign left_addr  = {row_reg, k_idx};
    assign right_addr = {k_idx, col_reg};

    assign mac_ctrl.acc_load = (state_reg == ST_CALC) && (step_reg == mm4_pkg::STEP_W'(1));
    assign mac_ctrl.acc_add  = (state_reg == ST_CALC) && (step_reg > mm4_pkg::STEP_W'(1))
                            && (step_reg <= STEP_ADD_END);

    assign elem_last = (row_reg == IDX_MAX) && (col_reg == IDX_MAX);

    mm4_mac u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .op_a   (left_store_reg[left_addr]),
        .op_b   (right_store_reg[right_addr]),
        .result (mac_result),
        .sat    (mac_sat)
    );

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_take && s_tlast) begin
                    state_next = ST_CALC;
                    step_next  = '0;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            ST_CALC: begin
                if (step_reg == STEP_LAST) begin
                    state_next = ST_SEND;
                end else begin
                    step_next = step_reg + mm4_pkg::STEP_W'(1);
                end
            end
            ST_SEND: begin
                if (m_tready) begin
                    step_next = '0;
                    if (elem_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_CALC;
                        if (col_reg == IDX_MAX) begin
                            col_next = '0;
                            row_next = row_reg + IW'(1);
                        end else begin
                            col_next = col_reg + IW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < mm4_pkg::CELLS; i++) begin
                left_store_reg[i]  <= '0;
                right_store_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (in_take && in_range) begin
                left_store_reg[{in_row, in_col}]  <= in_left;
                right_store_reg[{in_row, in_col}] <= in_right;
            end
            // Present the finished element; drop it once the sink takes it.
            if ((state_reg == ST_CALC) && (step_reg == STEP_LAST)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_CALC) && (step_reg == STEP_LAST)) begin
            m_data_reg <= mm4_pkg::M_TDATA_W'({mac_result, col_reg, row_reg});
            m_sat_reg  <= mac_sat;
            m_last_reg <= elem_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;
    assign m_tlast  = m_last_reg;

endmodule

### verif/tb_matrix_multiply_4x4_unit.sv
module tb_matrix_multiply_4x4_unit;

    localparam int SUM_W       = 2 * mm4_pkg::VAL_W + 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;
    localparam int IDLE_PCT    = 12;
    localparam int RANDOM_HALF = 180;
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_LEN    = 400;

    localparam logic signed [SUM_W-1:0] Q_MAX = 2147483647;
    localparam logic signed [SUM_W-1:0] Q_MIN = -Q_MAX - 1;

    typedef struct packed {
        logic [mm4_pkg::IDX_W-1:0] row;
        logic [mm4_pkg::IDX_W-1:0] column;
        logic [mm4_pkg::VAL_W-1:0] left_value;
        logic [mm4_pkg::VAL_W-1:0] right_value;
        logic                      last;
    } load_t;

    typedef struct packed {
        logic [mm4_pkg::IDX_W-1:0] out_row;
        logic [mm4_pkg::IDX_W-1:0] out_column;
        logic [mm4_pkg::VAL_W-1:0] product_value;
        logic                      saturated;
        logic                      last_out;
    } element_t;

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mm4_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic                            s_tlast  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [mm4_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    matrix_multiply_4x4_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    load_t                     pending_loads[$];
    element_t                  product_queue[$];
    logic [mm4_pkg::VAL_W-1:0] left_store [mm4_pkg::CELLS];
    logic [mm4_pkg::VAL_W-1:0] right_store[mm4_pkg::CELLS];

    load_t    offered;
    element_t seen;
    element_t wanted;
    int       offered_count  = 0;
    int       accepted_count = 0;
    int       result_count   = 0;
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       hold_cycles    = 0;
    bit       hold_done      = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Element (r, c): exact sum of four products, floored by the shift, then clipped.
    function automatic element_t product_element(int r, int c);
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] scaled;
        element_t e;
        sum = '0;
        for (int k = 0; k < mm4_pkg::DIM; k++)
            sum += $signed(left_store[r*mm4_pkg::DIM+k])
                 * $signed(right_store[k*mm4_pkg::DIM+c]);
        scaled = sum >>> mm4_pkg::FRAC_BITS;
        e.out_row    = mm4_pkg::IDX_W'(r);
        e.out_column = mm4_pkg::IDX_W'(c);
        e.last_out   = (r == mm4_pkg::DIM - 1) && (c == mm4_pkg::DIM - 1);
        e.saturated  = 1'b1;
        if (scaled > Q_MAX)
            e.product_value = Q_MAX[mm4_pkg::VAL_W-1:0];
        else if (scaled < Q_MIN)
            e.product_value = Q_MIN[mm4_pkg::VAL_W-1:0];
        else begin
            e.product_value = scaled[mm4_pkg::VAL_W-1:0];
            e.saturated     = 1'b0;
        end
        return e;
    endfunction

    // Write both stores, then on a last mark queue the whole product row by row.
    task automatic apply_load(load_t ld);
        left_store[ld.row*mm4_pkg::DIM+ld.column]  = ld.left_value;
        right_store[ld.row*mm4_pkg::DIM+ld.column] = ld.right_value;
        if (ld.last)
            for (int r = 0; r < mm4_pkg::DIM; r++)
                for (int c = 0; c < mm4_pkg::DIM; c++)
                    product_queue.insert(product_queue.size(), product_element(r, c));
    endtask

    function automatic logic [mm4_pkg::S_TDATA_W-1:0] pack_load(load_t ld);
        logic [mm4_pkg::S_TDATA_W-1:0] word;
        word = '0;
        word[mm4_pkg::IDX_W-1:0]                                = ld.row;
        word[mm4_pkg::IDX_W +: mm4_pkg::IDX_W]                  = ld.column;
        word[2*mm4_pkg::IDX_W +: mm4_pkg::VAL_W]                = ld.left_value;
        word[2*mm4_pkg::IDX_W+mm4_pkg::VAL_W +: mm4_pkg::VAL_W] = ld.right_value;
        return word;
    endfunction

    task automatic push_load(int r, int c, logic [mm4_pkg::VAL_W-1:0] lv,
                             logic [mm4_pkg::VAL_W-1:0] rv, logic last);
        load_t ld;
        ld.row         = mm4_pkg::IDX_W'(r);
        ld.column      = mm4_pkg::IDX_W'(c);
        ld.left_value  = lv;
        ld.right_value = rv;
        ld.last        = last;
        pending_loads.insert(pending_loads.size(), ld);
    endtask

    // Mostly moderate Q16.16 values so sums stay in range; extremes now and then.
    function automatic logic [mm4_pkg::VAL_W-1:0] random_value();
        logic [mm4_pkg::VAL_W-1:0] v;
        v = $urandom;
        case ($urandom_range(9)) inside
            [0:4]:   v = {{(mm4_pkg::VAL_W-21){v[20]}}, v[20:0]};
            [5:6]:   v = v;
            7:       v = {1'b0, {(mm4_pkg::VAL_W-1){1'b1}}};
            8:       v = {1'b1, {(mm4_pkg::VAL_W-1){1'b0}}};
            default: v = {{(mm4_pkg::VAL_W-8){v[31]}}, v[7:0]};
        endcase
        return v;
    endfunction

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            push_load($urandom_range(mm4_pkg::DIM - 1), $urandom_range(mm4_pkg::DIM - 1),
                      random_value(), random_value(), $urandom_range(7) == 0);
    endtask

    // Wait until every request is taken and every element has come back.
    task automatic wait_drained();
        while (pending_loads.size() != 0 || offered_count != accepted_count ||
               product_queue.size() != 0)
            @(posedge aclk);
    endtask

    // Driver: hold a request until taken, idle now and then between requests.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_load(offered);
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_loads.size() != 0 &&
                    ((accepted_count >= 100 && accepted_count < 200) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    offered = pending_loads.pop_front();
                    offered_count++;
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_load(offered);
                    s_tlast  <= offered.last;
                end else begin
                    s_tvalid <= 1'b0;
                    s_tlast  <= 1'b0;
                end
            end
        end
    end

    // Count down one long hold-off of the sink.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles <= 0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && result_count >= HOLD_AFTER) begin
            hold_done   <= 1'b1;
            hold_cycles <= HOLD_LEN;
        end
    end

    // Monitor and sink: check each element, stall at random and during the hold.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_count++;
                seen.out_row       = m_tdata[mm4_pkg::IDX_W-1:0];
                seen.out_column    = m_tdata[mm4_pkg::IDX_W +: mm4_pkg::IDX_W];
                seen.product_value = m_tdata[2*mm4_pkg::IDX_W +: mm4_pkg::VAL_W];
                seen.saturated     = m_tuser;
                seen.last_out      = m_tlast;
                if (product_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected element: row %0d col %0d value %h sat %b last %b",
                                 seen.out_row, seen.out_column, seen.product_value,
                                 seen.saturated, seen.last_out);
                end else begin
                    wanted = product_queue.pop_front();
                    if (seen !== wanted) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp r%0d c%0d v%h s%b l%b, got r%0d c%0d v%h s%b l%b",
                                     wanted.out_row, wanted.out_column, wanted.product_value,
                                     wanted.saturated, wanted.last_out,
                                     seen.out_row, seen.out_column, seen.product_value,
                                     seen.saturated, seen.last_out);
                    end
                end
            end
            if (hold_cycles != 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= (result_count >= 350 && result_count < 600) ||
                            $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < mm4_pkg::CELLS; i++) begin
            left_store[i]  = '0;
            right_store[i] = '0;
        end

        // Product of cleared stores with one corner at the extremes: clip low.
        push_load(3, 3, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        // Identity on the left passes the right matrix straight through.
        for (int r = 0; r < mm4_pkg::DIM; r++)
            for (int c = 0; c < mm4_pkg::DIM; c++)
                push_load(r, c, (r == c) ? 32'h0001_0000 : 32'h0, random_value(),
                          (r == mm4_pkg::DIM - 1) && (c == mm4_pkg::DIM - 1));
        // Overwrite one element of the kept stores and multiply again: clip high.
        push_load(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        // Tiny negative product rounds towards minus infinity.
        push_load(2, 2, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        push_load(1, 2, 32'h8000_0000, 32'h8000_0000, 1'b0);
        push_load(0, 1, 32'h0, 32'h0, 1'b1);
        wait_drained();

        push_random(RANDOM_HALF);
        // Pause the source until every element has come back.
        wait_drained();
        push_random(RANDOM_HALF);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && product_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
